/* rtl/gsp_pkg.sv */
// Shared types and constants for the scaled 8x8 glyph pixel intensity block.
// Used by gsp_coord, gsp_area and glyph8x8_scaled_pixel_intensity.
`default_nettype none
package gsp_pkg;

	localparam int GLYPH_W   = 64;
	localparam int COORD_W   = 8;
	localparam int SIZE_W    = 9;
	localparam int IDX_W     = 3;
	localparam int OVL_W     = 4;
	localparam int AREA_W    = 7;
	localparam int INTEN_W   = 8;
	localparam int IN_DATA_W = 80;

	localparam logic [SIZE_W-1:0]  SIZE_RESET = 9'd8;
	localparam logic [SIZE_W-1:0]  SIZE_NATIVE = 9'd8;
	localparam logic [AREA_W-1:0]  AREA_FULL = 7'd64;
	localparam logic [INTEN_W-1:0] INTEN_ON = 8'hFF;
	localparam logic [INTEN_W-1:0] INTEN_OFF = 8'h00;

	typedef logic [7:0][OVL_W-1:0] ovl_vec_t;

	typedef struct packed {
		logic               valid;
		logic               invalid;
		logic               down;
		logic               up_bit;
		logic [GLYPH_W-1:0] glyph;
		ovl_vec_t           oy;
		ovl_vec_t           ox;
	} cov_t;

	typedef struct packed {
		logic              valid;
		logic              invalid;
		logic              down;
		logic              up_bit;
		logic [AREA_W-1:0] area;
	} area_t;

endpackage
`default_nettype wire

/* rtl/glyph8x8_scaled_pixel_intensity.sv */
// Top level of the scaled 8x8 glyph pixel intensity block.
// Instantiates gsp_coord and gsp_area; uses gsp_pkg.
//
// Takes one pixel beat per clock while the output is not held and returns one
// result beat for each, in order. The five stages are input capture, index and
// overlap calculation, per-row coverage, the weighted area sum and the output
// register; a held output stalls all stages together.
// glyph_size is written through cfg_wr_en / cfg_wr_data and is saturated to
// MAX_GLYPH_SIZE; write it only while no beat is in flight.
`default_nettype none
module glyph8x8_scaled_pixel_intensity #(
	parameter int MAX_GLYPH_SIZE = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [gsp_pkg::SIZE_W-1:0]  cfg_wr_data,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// glyph_bits[63:0], pixel_row[71:64], pixel_col[79:72]
	input  wire logic [gsp_pkg::IN_DATA_W-1:0] s_tdata,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// intensity[7:0]
	output logic [gsp_pkg::INTEN_W-1:0]      m_tdata,
	// coord_invalid[0]
	output logic                             m_tuser
);

	localparam logic [gsp_pkg::SIZE_W-1:0] SIZE_CAP =
		(MAX_GLYPH_SIZE > 511) ? 9'd511 : gsp_pkg::SIZE_W'(MAX_GLYPH_SIZE);

	logic [gsp_pkg::SIZE_W-1:0]  size_q;
	logic [gsp_pkg::SIZE_W-1:0]  size_eff;
	logic                        en;
	gsp_pkg::cov_t               cov;
	gsp_pkg::area_t              area;
	logic [14:0]                 scaled;
	logic [gsp_pkg::INTEN_W-1:0] inten_nx;
	logic                        valid_s5;
	logic [gsp_pkg::INTEN_W-1:0] inten_s5;
	logic                        invalid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= gsp_pkg::SIZE_RESET;
		end else if (cfg_wr_en) begin
			size_q <= cfg_wr_data;
		end
	end

	assign size_eff = (size_q > SIZE_CAP) ? SIZE_CAP : size_q;

	// advance every stage unless the output beat is held
	assign en       = !valid_s5 || m_tready;
	assign s_tready = en;

	gsp_coord u_coord (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.in_data  (s_tdata),
		.size     (size_eff),
		.cov      (cov)
	);

	gsp_area u_area (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cov    (cov),
		.area   (area)
	);

	// round(area * 255 / 64), halves up
	assign scaled = {area.area, 8'b0} - 15'(area.area) + 15'd32;

	always_comb begin
		if (area.invalid) begin
			inten_nx = gsp_pkg::INTEN_OFF;
		end else if (area.down) begin
			inten_nx = scaled[13:6];
		end else begin
			inten_nx = area.up_bit ? gsp_pkg::INTEN_ON : gsp_pkg::INTEN_OFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= area.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inten_s5   <= inten_nx;
			invalid_s5 <= area.invalid;
		end
	end

	assign m_tvalid = valid_s5;
	assign m_tdata  = inten_s5;
	assign m_tuser  = invalid_s5;

	a_invalid_dark: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == gsp_pkg::INTEN_OFF)
		else $error("out-of-range pixel with non-zero intensity");

	a_up_binary: assert property (@(posedge clk) disable iff (!arst_n)
		area.valid && !area.invalid && !area.down |->
			inten_nx == gsp_pkg::INTEN_OFF || inten_nx == gsp_pkg::INTEN_ON)
		else $error("nearest-bit pixel not fully off or on");

	a_s4_moves: assert property (@(posedge clk) disable iff (!arst_n)
		area.valid && en |=> m_tvalid)
		else $error("beat lost between area stage and output");

endmodule
`default_nettype wire

/* rtl/gsp_coord.sv */
// Coordinate stages: capture the beat, flag out-of-range pixels, pick the
// nearest source bit and work out per-row and per-column box overlaps. Uses gsp_pkg.
`default_nettype none
module gsp_coord (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [gsp_pkg::IN_DATA_W-1:0] in_data,
	input  wire logic [gsp_pkg::SIZE_W-1:0]    size,
	output gsp_pkg::cov_t                      cov
);

	logic                          valid_s1;
	logic                          invalid_s1;
	logic                          down_s1;
	logic [gsp_pkg::GLYPH_W-1:0]   glyph_s1;
	logic [gsp_pkg::COORD_W-1:0]   row_s1;
	logic [gsp_pkg::COORD_W-1:0]   col_s1;
	logic [gsp_pkg::GLYPH_W-1:0]   glyph_in;
	logic [gsp_pkg::COORD_W-1:0]   row_in;
	logic [gsp_pkg::COORD_W-1:0]   col_in;
	logic [gsp_pkg::IDX_W-1:0]     k_idx;
	logic [gsp_pkg::IDX_W-1:0]     l_idx;
	gsp_pkg::ovl_vec_t             oy_nx;
	gsp_pkg::ovl_vec_t             ox_nx;
	gsp_pkg::cov_t                 cov_s2;

	assign glyph_in = in_data[63:0];
	assign row_in   = in_data[71:64];
	assign col_in   = in_data[79:72];

	function automatic logic [gsp_pkg::OVL_W-1:0] overlap(
		input logic [2:0] k,
		input logic [2:0] p,
		input logic [2:0] s
	);
		logic [6:0] lo_s, hi_s, lo_o, hi_o, lo, hi;
		lo_s = 7'(k) * 7'(s);
		hi_s = lo_s + 7'(s);
		lo_o = {1'b0, p, 3'b000};
		hi_o = lo_o + 7'd8;
		lo = (lo_s > lo_o) ? lo_s : lo_o;
		hi = (hi_s < hi_o) ? hi_s : hi_o;
		return (hi > lo) ? gsp_pkg::OVL_W'(hi - lo) : '0;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			glyph_s1   <= glyph_in;
			row_s1     <= row_in;
			col_s1     <= col_in;
			invalid_s1 <= ({1'b0, row_in} >= size) || ({1'b0, col_in} >= size);
			down_s1    <= size < gsp_pkg::SIZE_NATIVE;
		end
	end

	// nearest source index: count thresholds t*size that 8*coord reaches
	always_comb begin
		logic [11:0] th;
		k_idx = '0;
		l_idx = '0;
		for (int t = 1; t < 8; t++) begin
			th = 12'(size) * 12'(t);
			if ({1'b0, row_s1, 3'b000} >= th) begin
				k_idx = k_idx + 3'd1;
			end
			if ({1'b0, col_s1, 3'b000} >= th) begin
				l_idx = l_idx + 3'd1;
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			oy_nx[k] = overlap(3'(k), row_s1[2:0], size[2:0]);
			ox_nx[k] = overlap(3'(k), col_s1[2:0], size[2:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cov_s2 <= '0;
		end else if (en) begin
			cov_s2.valid   <= valid_s1;
			cov_s2.invalid <= invalid_s1;
			cov_s2.down    <= down_s1;
			cov_s2.up_bit  <= glyph_s1[{k_idx, l_idx}];
			cov_s2.glyph   <= glyph_s1;
			cov_s2.oy      <= oy_nx;
			cov_s2.ox      <= ox_nx;
		end
	end

	assign cov = cov_s2;

endmodule
`default_nettype wire

/* rtl/gsp_area.sv */
// Box-filter area stages: per-row lit coverage, then the weighted sum over rows.
// Uses gsp_pkg.
`default_nettype none
module gsp_area (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire gsp_pkg::cov_t  cov,
	output gsp_pkg::area_t area
);

	logic                        valid_s3;
	logic                        invalid_s3;
	logic                        down_s3;
	logic                        up_bit_s3;
	gsp_pkg::ovl_vec_t           oy_s3;
	gsp_pkg::ovl_vec_t           rs_s3;
	gsp_pkg::ovl_vec_t           rs_nx;
	logic [10:0]                 sum_nx;
	gsp_pkg::area_t              area_s4;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			rs_nx[k] = '0;
			for (int l = 0; l < 8; l++) begin
				if (cov.glyph[8*k + l]) begin
					rs_nx[k] = rs_nx[k] + cov.ox[l];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= cov.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			invalid_s3 <= cov.invalid;
			down_s3    <= cov.down;
			up_bit_s3  <= cov.up_bit;
			oy_s3      <= cov.oy;
			rs_s3      <= rs_nx;
		end
	end

	always_comb begin
		sum_nx = '0;
		for (int k = 0; k < 8; k++) begin
			sum_nx = sum_nx + (11'(oy_s3[k]) * 11'(rs_s3[k]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_s4 <= '0;
		end else if (en) begin
			area_s4.valid   <= valid_s3;
			area_s4.invalid <= invalid_s3;
			area_s4.down    <= down_s3;
			area_s4.up_bit  <= up_bit_s3;
			area_s4.area    <= (sum_nx > 11'(gsp_pkg::AREA_FULL)) ?
				gsp_pkg::AREA_FULL : gsp_pkg::AREA_W'(sum_nx);
		end
	end

	assign area = area_s4;

	a_area_bound: assert property (@(posedge clk) disable iff (!arst_n)
		area_s4.valid && area_s4.down && !area_s4.invalid |->
			area_s4.area <= gsp_pkg::AREA_FULL)
		else $error("box area above full coverage");

endmodule
`default_nettype wire
